// File: sv/box_non_max_suppression_unit_defines.svh
// Assertion macros used by the box suppression datapath.
`ifndef BOX_NON_MAX_SUPPRESSION_UNIT_DEFINES_SVH
`define BOX_NON_MAX_SUPPRESSION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BNMS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BNMS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bnms_pkg.sv
// Shared constants, command and status types for the box suppression unit.
package bnms_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int COORD_W       = 16;
    localparam int CLASS_W       = 8;
    localparam int SCORE_W       = 16;
    localparam int THR_W         = 17;
    localparam int BOX_W         = 4 * COORD_W + CLASS_W + SCORE_W;
    localparam int OVL_W         = 20;

    localparam logic [THR_W-1:0] THR_RESET = 17'd29491;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic i_clr;
        logic i_inc;
        logic j_clr;
        logic j_from_i;
        logic j_inc;
        logic rd_a;
        logic a_sel_j;
        logic rd_b;
        logic kill_i;
        logic kill_j;
        logic take;
        logic flush;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic i_end;
        logic j_end;
        logic alive_i;
        logic alive_j;
        logic hit;
        logic score_gt;
        logic out_free;
        logic held_valid;
    } sts_t;

    // Doubled overlap along one axis: min(2c1+s1, 2c2+s2) - max(2c1-s1, 2c2-s2).
    function automatic logic signed [OVL_W-1:0] overlap2(
        input logic [COORD_W-1:0] c1,
        input logic [COORD_W-1:0] s1,
        input logic [COORD_W-1:0] c2,
        input logic [COORD_W-1:0] s2
    );
        logic signed [OVL_W-1:0] l1;
        logic signed [OVL_W-1:0] l2;
        logic signed [OVL_W-1:0] r1;
        logic signed [OVL_W-1:0] r2;
        logic signed [OVL_W-1:0] lft;
        logic signed [OVL_W-1:0] rgt;
        l1  = $signed({3'b000, c1, 1'b0}) - $signed({4'b0000, s1});
        l2  = $signed({3'b000, c2, 1'b0}) - $signed({4'b0000, s2});
        r1  = $signed({3'b000, c1, 1'b0}) + $signed({4'b0000, s1});
        r2  = $signed({3'b000, c2, 1'b0}) + $signed({4'b0000, s2});
        lft = (l1 > l2) ? l1 : l2;
        rgt = (r1 < r2) ? r1 : r2;
        return rgt - lft;
    endfunction

endpackage

// File: sv/bnms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/bnms_datapath.sv
// Datapath: box stores, alive flags, index counters, IoU pipeline and output stage.
`include "box_non_max_suppression_unit_defines.svh"

module bnms_datapath #(
    parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bnms_pkg::cmd_t                cmd,
    output bnms_pkg::sts_t                sts,
    input  logic [bnms_pkg::BOX_W-1:0]    in_data,
    input  logic                          cfg_valid,
    input  logic [bnms_pkg::THR_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bnms_pkg::BOX_W-1:0]    out_data,
    output logic                          out_last
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int CW    = bnms_pkg::COORD_W;
    localparam int BW    = bnms_pkg::BOX_W;
    localparam int TW    = bnms_pkg::THR_W;
    localparam int SW    = bnms_pkg::SCORE_W;
    localparam int CLW   = bnms_pkg::CLASS_W;

    logic [TW-1:0]        thr_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     i_reg;
    logic [CNT_W-1:0]     j_reg;
    logic [MAX_BOXES-1:0] alive_reg;
    logic [BW-1:0]        held_reg;
    logic                 held_valid_reg;
    logic                 out_valid_reg;
    logic [BW-1:0]        out_data_reg;
    logic                 out_last_reg;

    logic                 full;
    logic                 wr_en;
    logic [IDX_W-1:0]     a_addr;
    logic [BW-1:0]        a_data;
    logic [BW-1:0]        b_data;

    logic signed [bnms_pkg::OVL_W-1:0] ow;
    logic signed [bnms_pkg::OVL_W-1:0] oh;
    logic [17:0]          ow_reg;
    logic [17:0]          oh_reg;
    logic                 neg_reg;
    logic [35:0]          inter_reg;
    logic [31:0]          area_a_reg;
    logic [31:0]          area_b_reg;
    logic [35:0]          union_reg;
    logic [34:0]          plo_reg;
    logic [34:0]          phi_reg;
    logic [53:0]          lhs;
    logic [53:0]          rhs;
    logic                 match;
    logic                 push;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= bnms_pkg::THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Store writes while loading; boxes beyond capacity are ignored.
    assign full  = (n_reg == CNT_W'(MAX_BOXES));
    assign wr_en = cmd.load && !full;

    // Two copies of the box store give one read port for box i and one for box j.
    assign a_addr = cmd.a_sel_j ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];

    bnms_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (n_reg[IDX_W-1:0]),
        .wr_data (in_data),
        .rd_en   (cmd.rd_a),
        .rd_addr (a_addr),
        .rd_data (a_data)
    );

    bnms_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (n_reg[IDX_W-1:0]),
        .wr_data (in_data),
        .rd_en   (cmd.rd_b),
        .rd_addr (j_reg[IDX_W-1:0]),
        .rd_data (b_data)
    );

    // Counters and alive flags; a box is marked alive as it is stored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            alive_reg <= '1;
        end
        else
        begin
            if (cmd.flush)
            begin
                n_reg <= '0;
            end
            else
            begin
                if (wr_en)
                begin
                    n_reg                        <= n_reg + 1'b1;
                    alive_reg[n_reg[IDX_W-1:0]] <= 1'b1;
                end
                if (cmd.kill_i)
                begin
                    alive_reg[i_reg[IDX_W-1:0]] <= 1'b0;
                end
                if (cmd.kill_j)
                begin
                    alive_reg[j_reg[IDX_W-1:0]] <= 1'b0;
                end
            end
            if (cmd.i_clr)
            begin
                i_reg <= '0;
            end
            else if (cmd.i_inc)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.j_clr)
            begin
                j_reg <= '0;
            end
            else if (cmd.j_from_i)
            begin
                j_reg <= i_reg + 1'b1;
            end
            else if (cmd.j_inc)
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    // IoU stage 1: doubled overlaps of the two boxes.
    assign ow = bnms_pkg::overlap2(a_data[CW-1:0], a_data[3*CW-1:2*CW],
                                   b_data[CW-1:0], b_data[3*CW-1:2*CW]);
    assign oh = bnms_pkg::overlap2(a_data[2*CW-1:CW], a_data[4*CW-1:3*CW],
                                   b_data[2*CW-1:CW], b_data[4*CW-1:3*CW]);

    // IoU stages 1 to 4: overlap, products, union, threshold partial products.
    always_ff @(posedge clk)
    begin
        ow_reg     <= ow[17:0];
        oh_reg     <= oh[17:0];
        neg_reg    <= ow[bnms_pkg::OVL_W-1] | oh[bnms_pkg::OVL_W-1];
        inter_reg  <= ow_reg * oh_reg;
        area_a_reg <= a_data[3*CW-1:2*CW] * a_data[4*CW-1:3*CW];
        area_b_reg <= b_data[3*CW-1:2*CW] * b_data[4*CW-1:3*CW];
        union_reg  <= {2'b00, area_a_reg, 2'b00} + {2'b00, area_b_reg, 2'b00} - inter_reg;
        plo_reg    <= thr_reg * union_reg[17:0];
        phi_reg    <= thr_reg * union_reg[35:18];
    end

    // Final compare: inter * 65536 >= threshold * union.
    assign lhs   = {2'b00, inter_reg, 16'h0000};
    assign rhs   = {1'b0, phi_reg, 18'h00000} + {19'h00000, plo_reg};
    assign match = neg_reg ? (thr_reg == '0) : ((union_reg != '0) && (lhs >= rhs));

    // Output register with a one-box holding stage, so the last survivor is known.
    assign push = (cmd.take && held_valid_reg) || cmd.flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.take)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                held_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= held_reg;
            out_last_reg <= cmd.flush;
        end
        if (cmd.take)
        begin
            held_reg <= a_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    // Status back to the controller.
    assign sts.i_end      = (i_reg == n_reg);
    assign sts.j_end      = (j_reg == n_reg);
    assign sts.alive_i    = alive_reg[i_reg[IDX_W-1:0]];
    assign sts.alive_j    = alive_reg[j_reg[IDX_W-1:0]];
    assign sts.hit        = match && (a_data[BW-SW-1:BW-SW-CLW] == b_data[BW-SW-1:BW-SW-CLW]);
    assign sts.score_gt   = (b_data[BW-1:BW-SW] > a_data[BW-1:BW-SW]);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.held_valid = held_valid_reg;

    // Checks on the datapath.
    `BNMS_ASSERT_IMP(a_no_double_kill, cmd.kill_i, !cmd.kill_j, "both boxes of a pair dropped")
    `BNMS_ASSERT_IMP(a_flush_has_box, cmd.flush, held_valid_reg, "set ended without a survivor")
    `BNMS_ASSERT_IMP(a_count_bound, 1'b1, n_reg <= CNT_W'(MAX_BOXES), "box count over capacity")
    `BNMS_ASSERT_NXT(a_flush_clears, cmd.flush, n_reg == '0, "box count not cleared after set")

endmodule

// File: sv/bnms_ctrl.sv
// Controller: sequences loading, the pairwise suppression scan and the output sweep.
module bnms_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    input  bnms_pkg::sts_t sts,
    output bnms_pkg::cmd_t cmd
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_SCAN_I = 4'd1;
    localparam logic [3:0] S_SCAN_J = 4'd2;
    localparam logic [3:0] S_W1     = 4'd3;
    localparam logic [3:0] S_W2     = 4'd4;
    localparam logic [3:0] S_W3     = 4'd5;
    localparam logic [3:0] S_W4     = 4'd6;
    localparam logic [3:0] S_DEC    = 4'd7;
    localparam logic [3:0] S_OSCAN  = 4'd8;
    localparam logic [3:0] S_OTAKE  = 4'd9;
    localparam logic [3:0] S_FLUSH  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_LOAD);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.i_clr  = 1'b1;
                        state_next = S_SCAN_I;
                    end
                end
            end
            S_SCAN_I:
            begin
                if (sts.i_end)
                begin
                    cmd.j_clr  = 1'b1;
                    state_next = S_OSCAN;
                end
                else if (!sts.alive_i)
                begin
                    cmd.i_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_a     = 1'b1;
                    cmd.j_from_i = 1'b1;
                    state_next   = S_SCAN_J;
                end
            end
            S_SCAN_J:
            begin
                if (sts.j_end)
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_SCAN_I;
                end
                else if (!sts.alive_j)
                begin
                    cmd.j_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_b   = 1'b1;
                    state_next = S_W1;
                end
            end
            S_W1:    state_next = S_W2;
            S_W2:    state_next = S_W3;
            S_W3:    state_next = S_W4;
            S_W4:    state_next = S_DEC;
            S_DEC:
            begin
                if (sts.hit && sts.score_gt)
                begin
                    cmd.kill_i = 1'b1;
                    cmd.i_inc  = 1'b1;
                    state_next = S_SCAN_I;
                end
                else
                begin
                    cmd.kill_j = sts.hit;
                    cmd.j_inc  = 1'b1;
                    state_next = S_SCAN_J;
                end
            end
            S_OSCAN:
            begin
                if (sts.j_end)
                begin
                    state_next = S_FLUSH;
                end
                else if (!sts.alive_j)
                begin
                    cmd.j_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_a    = 1'b1;
                    cmd.a_sel_j = 1'b1;
                    state_next  = S_OTAKE;
                end
            end
            S_OTAKE:
            begin
                if (!sts.held_valid || sts.out_free)
                begin
                    cmd.take   = 1'b1;
                    cmd.j_inc  = 1'b1;
                    state_next = S_OSCAN;
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

endmodule

// File: sv/box_non_max_suppression_unit.sv
// Top level of the box non-maximum suppression unit.
//
// Boxes stream in at one per cycle and are held until the box marked with tlast; up to
// MAX_BOXES are kept and later ones dropped. The set is then processed on one shared
// IoU pipeline: each surviving box is compared with every later surviving box until it
// is itself dropped, and the scan is bounded by that pipeline and the single read port
// of each store copy. Survivors then leave in load order, the last one marked with tlast;
// the sweep holds while the output is stalled, and the next set can load as soon as the
// last survivor sits in the output register. No input is taken during the scan and the
// output sweep. The threshold register is 17-bit unsigned Q1.16, reset 29491.
module box_non_max_suppression_unit #(
    parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Threshold write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bnms_pkg::THR_W-1:0]    cfg_data,
    // Box input: center_x, center_y, box_width, box_height, class_id, score.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bnms_pkg::BOX_W-1:0]    s_tdata,
    input  logic                          s_tlast,
    // Survivor output: out_center_x, out_center_y, out_width, out_height,
    // out_class, out_score.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bnms_pkg::BOX_W-1:0]    m_tdata,
    output logic                          m_tlast
);

    bnms_pkg::cmd_t cmd;
    bnms_pkg::sts_t sts;

    // The threshold register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    bnms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bnms_datapath #(.MAX_BOXES(MAX_BOXES)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// File: tb/sv/box_non_max_suppression_unit_test.sv
// Self-checking testbench for the box non-maximum suppression unit.
module box_non_max_suppression_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = bnms_pkg::MAX_BOXES_DEF;
    localparam int STALL_LIMIT = 200000;
    localparam int IDLE_PAUSE = 40;
    localparam int RANDOM_ITEMS = 210;

    // Box layout, packed so that center x sits in the lowest bits of tdata.
    typedef struct packed {
        logic [15:0] score;
        logic [7:0]  cls;
        logic [15:0] h;
        logic [15:0] w;
        logic [15:0] cy;
        logic [15:0] cx;
    } box_t;

    typedef struct {
        box_t box;
        logic last;
    } survivor_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [bnms_pkg::THR_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [bnms_pkg::BOX_W-1:0] s_tdata;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [bnms_pkg::BOX_W-1:0] m_tdata;
    logic m_tlast;

    // Predictor state: current threshold and the boxes held for this set.
    logic [16:0] threshold;
    box_t        held_boxes[$];
    survivor_t   pending_survivors[$];

    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int items_sent;

    box_non_max_suppression_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // IoU test without division, on doubled coordinates.
    function automatic logic overlaps_enough(box_t a, box_t b, logic [16:0] thr);
        longint ow;
        longint oh;
        longint lft;
        longint rgt;
        longint inter4;
        longint union4;
        lft = 2 * longint'(a.cx) - longint'(a.w);
        if (2 * longint'(b.cx) - longint'(b.w) > lft)
            lft = 2 * longint'(b.cx) - longint'(b.w);
        rgt = 2 * longint'(a.cx) + longint'(a.w);
        if (2 * longint'(b.cx) + longint'(b.w) < rgt)
            rgt = 2 * longint'(b.cx) + longint'(b.w);
        ow = rgt - lft;
        lft = 2 * longint'(a.cy) - longint'(a.h);
        if (2 * longint'(b.cy) - longint'(b.h) > lft)
            lft = 2 * longint'(b.cy) - longint'(b.h);
        rgt = 2 * longint'(a.cy) + longint'(a.h);
        if (2 * longint'(b.cy) + longint'(b.h) < rgt)
            rgt = 2 * longint'(b.cy) + longint'(b.h);
        oh = rgt - lft;
        if (ow < 0 || oh < 0)
            return thr == 17'd0;
        inter4 = ow * oh;
        union4 = 4 * longint'(a.w) * longint'(a.h) + 4 * longint'(b.w) * longint'(b.h)
                 - inter4;
        if (union4 == 0)
            return 1'b0;
        return inter4 * 65536 >= longint'(thr) * union4;
    endfunction

    // Suppress the held set and queue its survivors in load order.
    task automatic suppress_held_set();
        logic alive[$];
        int n;
        int last_idx;
        survivor_t s;
        n = held_boxes.size();
        alive = {};
        for (int k = 0; k < n; k++)
            alive = {alive, 1'b1};
        for (int i = 0; i < n; i++)
        begin
            if (!alive[i])
                continue;
            for (int j = i + 1; j < n; j++)
            begin
                if (!alive[j] || held_boxes[i].cls != held_boxes[j].cls)
                    continue;
                if (!overlaps_enough(held_boxes[j], held_boxes[i], threshold))
                    continue;
                if (held_boxes[j].score <= held_boxes[i].score)
                    alive[j] = 1'b0;
                else
                begin
                    alive[i] = 1'b0;
                    break;
                end
            end
        end
        last_idx = -1;
        for (int i = 0; i < n; i++)
            if (alive[i])
                last_idx = i;
        for (int i = 0; i < n; i++)
        begin
            if (!alive[i])
                continue;
            s.box = held_boxes[i];
            s.last = (i == last_idx);
            pending_survivors = {pending_survivors, s};
        end
        held_boxes = {};
    endtask

    // Send one box; the predictor records it once the transaction completes.
    task automatic send_box(box_t b, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (held_boxes.size() < CAPACITY)
            held_boxes = {held_boxes, b};
        if (last)
            suppress_held_set();
    endtask

    task automatic send_set(box_t boxes[$]);
        for (int k = 0; k < boxes.size(); k++)
            send_box(boxes[k], k == boxes.size() - 1);
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every survivor has come out and the unit has settled.
    task automatic wait_drained();
        while (pending_survivors.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_threshold(logic [16:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        threshold = value;
    endtask

    function automatic box_t make_box(int cx, int cy, int w, int h, int cls, int score);
        box_t b;
        b.cx = 16'(cx);
        b.cy = 16'(cy);
        b.w = 16'(w);
        b.h = 16'(h);
        b.cls = 8'(cls);
        b.score = 16'(score);
        return b;
    endfunction

    // Random box near a cluster center, or fully random as noise.
    function automatic box_t cluster_box(int ccx, int ccy, int base_cls);
        box_t b;
        logic [95:0] raw;
        if ($urandom_range(9) < 2)
        begin
            raw = {$urandom, $urandom, $urandom};
            b = raw[bnms_pkg::BOX_W-1:0];
            return b;
        end
        b.cx = 16'(ccx + int'($urandom_range(64)) - 32);
        b.cy = 16'(ccy + int'($urandom_range(64)) - 32);
        b.w = 16'($urandom_range(400, 40));
        b.h = 16'($urandom_range(400, 40));
        b.cls = 8'(base_cls + int'($urandom_range(1)));
        b.score = 16'($urandom);
        if ($urandom_range(7) == 0)
            b.score = 16'hFFFF;
        return b;
    endfunction

    task automatic test_single_boxes();
        box_t set[$];
        set = {make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF)};
        send_set(set);
        set = {make_box(0, 0, 0, 0, 0, 0)};
        send_set(set);
    endtask

    task automatic test_score_order();
        box_t set[$];
        // Equal scores: the later box goes.
        set = {make_box(1000, 1000, 200, 200, 3, 500), make_box(1004, 1000, 200, 200, 3, 500)};
        send_set(set);
        // A later box with a higher score drops the earlier one.
        set = {make_box(1000, 1000, 200, 200, 3, 400), make_box(1002, 1002, 200, 200, 3, 900),
               make_box(1001, 999, 200, 200, 3, 100)};
        send_set(set);
        // Different classes never suppress each other.
        set = {make_box(1000, 1000, 200, 200, 3, 400), make_box(1000, 1000, 200, 200, 4, 900)};
        send_set(set);
    endtask

    task automatic test_geometry_corners();
        box_t set[$];
        // Disjoint, touching and zero-area pairs.
        set = {make_box(100, 100, 20, 20, 1, 50), make_box(500, 500, 20, 20, 1, 60)};
        send_set(set);
        set = {make_box(100, 100, 20, 20, 1, 50), make_box(120, 100, 20, 20, 1, 60)};
        send_set(set);
        set = {make_box(300, 300, 0, 0, 1, 50), make_box(300, 300, 0, 0, 1, 60)};
        send_set(set);
    endtask

    task automatic test_threshold_extremes();
        box_t set[$];
        set = {make_box(100, 100, 20, 20, 1, 50), make_box(500, 500, 20, 20, 1, 60),
               make_box(120, 100, 20, 20, 1, 70)};
        write_threshold(17'd0);
        send_set(set);
        set = {make_box(800, 800, 64, 64, 9, 70), make_box(800, 800, 64, 64, 9, 20)};
        write_threshold(17'd65536);
        send_set(set);
        write_threshold(17'h1FFFF);
        send_set(set);
        write_threshold(17'd29491);
    endtask

    // More boxes than the store holds; the marked box past capacity is dropped.
    task automatic test_store_overflow();
        box_t set[$];
        set = {};
        for (int k = 0; k < CAPACITY + 2; k++)
            set = {set, cluster_box(20000, 20000, 7)};
        send_set(set);
    endtask

    // Random sets under each idle mode, with a new threshold between modes.
    task automatic test_random_sets();
        box_t set[$];
        int mode;
        int size;
        int ccx;
        int ccy;
        int base_cls;
        logic [16:0] thr_choices[$];
        thr_choices = {17'd16384, 17'd0, 17'd65536, 17'd45000, 17'h1FFFF, 17'd29491};
        mode = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= (mode + 1) * RANDOM_ITEMS / 4)
            begin
                mode++;
                write_threshold(mode < thr_choices.size() ? thr_choices[mode]
                                                          : 17'($urandom));
            end
            case (mode % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 54; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 54; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if ($urandom_range(5) == 0)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            size = ($urandom_range(40) == 0) ? CAPACITY : $urandom_range(8, 1);
            ccx = $urandom_range(60000, 1000);
            ccy = $urandom_range(60000, 1000);
            base_cls = $urandom_range(254);
            set = {};
            for (int k = 0; k < size; k++)
                set = {set, cluster_box(ccx, ccy, base_cls)};
            send_set(set);
        end
        write_threshold(17'($urandom_range(65536)));
        send_idle_pct = 33;
        recv_stall_pct = 33;
        for (int r = 0; r < 10; r++)
        begin
            set = {};
            for (int k = 0; k < 6; k++)
                set = {set, cluster_box(30000, 30000, 2)};
            send_set(set);
        end
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Receiver stalls and survivor checking.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                box_t act;
                survivor_t exp_s;
                act = m_tdata;
                if (pending_survivors.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected survivor, expected none, got %0h", $time, m_tdata);
                end
                else
                begin
                    exp_s = pending_survivors.pop_front();
                    check_field("out_center_x", exp_s.box.cx, act.cx);
                    check_field("out_center_y", exp_s.box.cy, act.cy);
                    check_field("out_width", exp_s.box.w, act.w);
                    check_field("out_height", exp_s.box.h, act.h);
                    check_field("out_class", exp_s.box.cls, act.cls);
                    check_field("out_score", exp_s.box.score, act.score);
                    check_field("last_out", exp_s.last, m_tlast);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        threshold = bnms_pkg::THR_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_boxes();
        test_score_order();
        test_geometry_corners();
        test_threshold_extremes();
        test_store_overflow();
        test_random_sets();
        wait_drained();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
